// ----- src/assert_macros.svh -----
// Assertion macros used by the bounding sphere merge top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define BSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies a property in the next cycle.
`define BSM_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- src/bsm_pkg.sv -----
// Shared constants and types for the bounding sphere merge pipeline.
`timescale 1ns / 1ps

package bsm_pkg;

    localparam int RAD_W    = 31;
    localparam int RSUM_W   = 32;
    localparam int GROWTH_W = 63;

    // merge case codes
    localparam logic [1:0] CASE_NEW    = 2'd0;
    localparam logic [1:0] CASE_KEEP_A = 2'd1;
    localparam logic [1:0] CASE_KEEP_B = 2'd2;

    // pipeline control handed to each unit
    typedef struct packed {
        logic adv;
        logic valid;
    } t_pipe_ctl;

endpackage

// ----- src/bounding_sphere_merge.sv -----
// Top level of the bounding sphere merge and overlap pipeline.
//
//  channel   handshake            payload
//  input     i_valid / o_ready    i_a_x i_a_y i_a_z i_a_radius i_b_x i_b_y i_b_z i_b_radius
//  output    o_valid / i_ready    o_overlap o_merge_case o_merged_x/y/z o_merged_radius o_growth
//
// One sphere pair enters per cycle while o_ready is high. The square root takes
// COORD_WIDTH + 1 stages and the three center dividers COORD_WIDTH stages, which make
// up most of the pipeline depth.
// Reset clears only valid bits; no clearing pass is needed.
// A stalled output beat is held in the output register and one more beat in a skid
// register; the pipeline freezes only while the skid register is full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bounding_sphere_merge #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_a_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_y,
    input  logic signed [COORD_WIDTH-1:0] i_a_z,
    input  logic [bsm_pkg::RAD_W-1:0]     i_a_radius,
    input  logic signed [COORD_WIDTH-1:0] i_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_z,
    input  logic [bsm_pkg::RAD_W-1:0]     i_b_radius,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_overlap,
    output logic [1:0]                    o_merge_case,
    output logic signed [COORD_WIDTH-1:0] o_merged_x,
    output logic signed [COORD_WIDTH-1:0] o_merged_y,
    output logic signed [COORD_WIDTH-1:0] o_merged_z,
    output logic [bsm_pkg::RAD_W-1:0]     o_merged_radius,
    output logic [bsm_pkg::GROWTH_W-1:0]  o_growth
);
    import bsm_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int MW  = W + 1;
    localparam int SQW = 2 * MW;
    localparam int NRW = ((W > RAD_W) ? W : RAD_W) + 1;
    localparam int SW  = NRW + 1;
    localparam int GW  = (2 * NRW > GROWTH_W) ? 2 * NRW : GROWTH_W;
    localparam int CW  = (SQW > 2 * RSUM_W) ? SQW : 2 * RSUM_W;
    localparam logic [GW-1:0]  GMAX = GW'({GROWTH_W{1'b1}});
    localparam logic [NRW-1:0] RMAX = NRW'({RAD_W{1'b1}});

    typedef struct packed {
        logic [W-1:0]  a;
        logic [W-1:0]  b;
        logic          neg;
        logic [MW-1:0] mag;
    } t_lane;

    typedef struct packed {
        t_lane [2:0]      lane;
        logic [RAD_W-1:0] ra;
        logic [RAD_W-1:0] rb;
        logic             ovl;
    } t_rt_tag;

    typedef struct packed {
        logic         neg;
        logic [W-1:0] base;
    } t_dl;

    typedef struct packed {
        logic [1:0]    mcase;
        logic          ovl;
        logic [MW-1:0] dlen;
    } t_ctag;

    typedef struct packed {
        logic                ovl;
        logic [1:0]          mcase;
        logic [RAD_W-1:0]    rad;
        logic [GROWTH_W-1:0] growth;
    } t_fin;

    typedef struct packed {
        logic                ovl;
        logic [1:0]          mcase;
        logic [2:0][W-1:0]   ctr;
        logic [RAD_W-1:0]    rad;
        logic [GROWTH_W-1:0] growth;
    } t_result;

    logic en;

    // ---------------- stage 1: center differences ----------------
    logic [2:0][W-1:0]  in_a;
    logic [2:0][W-1:0]  in_b;
    logic [2:0][MW-1:0] n1_mag;
    logic [2:0]         n1_neg;

    logic [2:0][W-1:0]  r1_a;
    logic [2:0][W-1:0]  r1_b;
    logic [2:0][MW-1:0] r1_mag;
    logic [2:0]         r1_neg;
    logic [RAD_W-1:0]   r1_ra;
    logic [RAD_W-1:0]   r1_rb;
    logic [RSUM_W-1:0]  r1_rsum;
    logic               r1_vld;

    assign in_a = {i_a_z, i_a_y, i_a_x};
    assign in_b = {i_b_z, i_b_y, i_b_x};

    // take both differences and keep the magnitude
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [MW-1:0] d_pos;
            logic [MW-1:0] d_neg;
            d_pos     = {in_b[i][W-1], in_b[i]} - {in_a[i][W-1], in_a[i]};
            d_neg     = {in_a[i][W-1], in_a[i]} - {in_b[i][W-1], in_b[i]};
            n1_neg[i] = d_pos[MW-1];
            n1_mag[i] = d_pos[MW-1] ? d_neg : d_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a    <= in_a;
            r1_b    <= in_b;
            r1_mag  <= n1_mag;
            r1_neg  <= n1_neg;
            r1_ra   <= i_a_radius;
            r1_rb   <= i_b_radius;
            r1_rsum <= RSUM_W'(i_a_radius) + RSUM_W'(i_b_radius);
        end
    end

    // ---------------- stages 2-3: squares ----------------
    t_pipe_ctl          ctl1;
    logic [2:0]         m1_vld;
    logic [2:0][SQW-1:0] m1_sq;
    t_lane [2:0]        m1_lane;
    logic [2*RSUM_W-1:0] m1_rsq;
    logic [2*RAD_W-1:0] m1_rad;

    assign ctl1 = '{adv: en, valid: r1_vld};

    for (genvar i = 0; i < 3; i++) begin : g_sq
        bsm_mul #(.AW(MW), .BW(MW), .TW($bits(t_lane))) u_sq (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl1),
            .i_a     (r1_mag[i]),
            .i_b     (r1_mag[i]),
            .i_tag   ({r1_a[i], r1_b[i], r1_neg[i], r1_mag[i]}),
            .o_valid (m1_vld[i]),
            .o_prod  (m1_sq[i]),
            .o_tag   (m1_lane[i])
        );
    end

    bsm_mul #(.AW(RSUM_W), .BW(RSUM_W), .TW(2 * RAD_W)) u_rsq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl1),
        .i_a     (r1_rsum),
        .i_b     (r1_rsum),
        .i_tag   ({r1_ra, r1_rb}),
        .o_valid (),
        .o_prod  (m1_rsq),
        .o_tag   (m1_rad)
    );

    // ---------------- stage 4: squared distance ----------------
    logic [SQW-1:0]      r4_dsq;
    logic [2*RSUM_W-1:0] r4_rsq;
    t_lane [2:0]         r4_lane;
    logic [2*RAD_W-1:0]  r4_rad;
    logic                r4_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= m1_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_dsq  <= m1_sq[0] + m1_sq[1] + m1_sq[2];
            r4_rsq  <= m1_rsq;
            r4_lane <= m1_lane;
            r4_rad  <= m1_rad;
        end
    end

    // ---------------- square root, overlap test rides along ----------------
    t_pipe_ctl ctl4;
    t_rt_tag   rt_in;
    t_rt_tag   rt_out;
    logic [MW-1:0] sq_root;
    logic          sq_vld;

    assign ctl4  = '{adv: en, valid: r4_vld};
    assign rt_in = '{lane: r4_lane, ra: r4_rad[2*RAD_W-1:RAD_W], rb: r4_rad[RAD_W-1:0],
                     ovl: (CW'(r4_dsq) < CW'(r4_rsq))};

    bsm_isqrt #(.RB(MW), .TW($bits(t_rt_tag))) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl4),
        .i_rad   (r4_dsq),
        .i_tag   (rt_in),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_tag   (rt_out)
    );

    // ---------------- stage C: containment and new radius ----------------
    logic [SW-1:0]  sum_br;
    logic [SW-1:0]  sum_ar;
    logic [SW-1:0]  newr_full;
    logic [SW:0]    tdiff;
    logic           keep_a;
    logic           keep_b;
    logic [NRW-1:0] n6_rm;
    logic [1:0]     n6_case;

    always_comb begin
        sum_br    = SW'(sq_root) + SW'(rt_out.rb);
        sum_ar    = SW'(sq_root) + SW'(rt_out.ra);
        newr_full = SW'(sq_root) + SW'(rt_out.ra) + SW'(rt_out.rb);
        tdiff     = (SW+1)'(sq_root) + (SW+1)'(rt_out.rb) - (SW+1)'(rt_out.ra);
        keep_a    = SW'(rt_out.ra) >= sum_br;
        keep_b    = !keep_a && (SW'(rt_out.rb) >= sum_ar);
        if (keep_a) begin
            n6_rm   = NRW'(rt_out.ra);
            n6_case = CASE_KEEP_A;
        end else if (keep_b) begin
            n6_rm   = NRW'(rt_out.rb);
            n6_case = CASE_KEEP_B;
        end else begin
            n6_rm   = newr_full[SW-1:1];
            n6_case = CASE_NEW;
        end
    end

    logic [2:0][MW-1:0] r6_mag;
    t_dl [2:0]          r6_dl;
    logic [MW-1:0]      r6_s;
    logic [MW-1:0]      r6_dist;
    logic [NRW-1:0]     r6_rm;
    logic [RAD_W-1:0]   r6_ra;
    logic [1:0]         r6_case;
    logic               r6_ovl;
    logic               r6_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r6_mag[i]     <= rt_out.lane[i].mag;
                r6_dl[i].neg  <= rt_out.lane[i].neg;
                r6_dl[i].base <= keep_b ? rt_out.lane[i].b : rt_out.lane[i].a;
            end
            r6_s    <= tdiff[MW:1];
            r6_dist <= sq_root;
            r6_rm   <= n6_rm;
            r6_ra   <= rt_out.ra;
            r6_case <= n6_case;
            r6_ovl  <= rt_out.ovl;
        end
    end

    // ---------------- offset and growth products ----------------
    t_pipe_ctl           ctl6;
    logic [2:0]          m2_vld;
    logic [2:0][SQW-1:0] m2_p;
    t_dl [2:0]           m2_dl;
    logic [2*NRW-1:0]    m2_rm2;
    logic [NRW-1:0]      m2_rm;
    logic [2*RAD_W-1:0]  m2_ra2;
    t_ctag               m2_ctag;

    assign ctl6 = '{adv: en, valid: r6_vld};

    for (genvar i = 0; i < 3; i++) begin : g_off
        bsm_mul #(.AW(MW), .BW(MW), .TW($bits(t_dl))) u_off (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl6),
            .i_a     (r6_mag[i]),
            .i_b     (r6_s),
            .i_tag   (r6_dl[i]),
            .o_valid (m2_vld[i]),
            .o_prod  (m2_p[i]),
            .o_tag   (m2_dl[i])
        );
    end

    bsm_mul #(.AW(NRW), .BW(NRW), .TW(NRW)) u_rm2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl6),
        .i_a     (r6_rm),
        .i_b     (r6_rm),
        .i_tag   (r6_rm),
        .o_valid (),
        .o_prod  (m2_rm2),
        .o_tag   (m2_rm)
    );

    bsm_mul #(.AW(RAD_W), .BW(RAD_W), .TW($bits(t_ctag))) u_ra2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl6),
        .i_a     (r6_ra),
        .i_b     (r6_ra),
        .i_tag   ({r6_case, r6_ovl, r6_dist}),
        .o_valid (),
        .o_prod  (m2_ra2),
        .o_tag   (m2_ctag)
    );

    // growth and radius saturation ride with the dividers
    logic [GW-1:0] gdiff;
    t_fin          fin_in;

    always_comb begin
        gdiff        = GW'(m2_rm2) - GW'(m2_ra2);
        fin_in.ovl   = m2_ctag.ovl;
        fin_in.mcase = m2_ctag.mcase;
        fin_in.rad   = (m2_rm > RMAX) ? RMAX[RAD_W-1:0] : m2_rm[RAD_W-1:0];
        fin_in.growth = (gdiff > GMAX) ? GMAX[GROWTH_W-1:0] : gdiff[GROWTH_W-1:0];
    end

    // ---------------- center dividers ----------------
    t_pipe_ctl         ctl8;
    logic [2:0]        dv_vld;
    logic [2:0][W-1:0] dv_quo;
    t_dl [2:0]         dv_dl;
    t_fin              dv_fin;

    assign ctl8 = '{adv: en, valid: m2_vld[0]};

    bsm_div #(.QB(W), .DW(MW), .TW($bits(t_fin) + $bits(t_dl))) u_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl8),
        .i_num   (m2_p[0][W+MW-1:0]),
        .i_den   (m2_ctag.dlen),
        .i_tag   ({fin_in, m2_dl[0]}),
        .o_valid (dv_vld[0]),
        .o_quo   (dv_quo[0]),
        .o_tag   ({dv_fin, dv_dl[0]})
    );

    bsm_div #(.QB(W), .DW(MW), .TW($bits(t_dl))) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl8),
        .i_num   (m2_p[1][W+MW-1:0]),
        .i_den   (m2_ctag.dlen),
        .i_tag   (m2_dl[1]),
        .o_valid (dv_vld[1]),
        .o_quo   (dv_quo[1]),
        .o_tag   (dv_dl[1])
    );

    bsm_div #(.QB(W), .DW(MW), .TW($bits(t_dl))) u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl8),
        .i_num   (m2_p[2][W+MW-1:0]),
        .i_den   (m2_ctag.dlen),
        .i_tag   (m2_dl[2]),
        .o_valid (dv_vld[2]),
        .o_quo   (dv_quo[2]),
        .o_tag   (dv_dl[2])
    );

    // ---------------- final: apply offset, saturate ----------------
    t_result n_res;
    logic    last_vld;

    assign last_vld = dv_vld[0];

    always_comb begin
        n_res.ovl    = dv_fin.ovl;
        n_res.mcase  = dv_fin.mcase;
        n_res.rad    = dv_fin.rad;
        n_res.growth = dv_fin.growth;
        for (int i = 0; i < 3; i++) begin
            logic [W+1:0] ssum;
            if (dv_dl[i].neg) begin
                ssum = {{2{dv_dl[i].base[W-1]}}, dv_dl[i].base} - {2'b00, dv_quo[i]};
            end else begin
                ssum = {{2{dv_dl[i].base[W-1]}}, dv_dl[i].base} + {2'b00, dv_quo[i]};
            end
            if (dv_fin.mcase != CASE_NEW) begin
                n_res.ctr[i] = dv_dl[i].base;
            end else if ((ssum[W+1:W-1] == 3'b000) || (ssum[W+1:W-1] == 3'b111)) begin
                n_res.ctr[i] = ssum[W-1:0];
            end else begin
                n_res.ctr[i] = {ssum[W+1], {(W-1){~ssum[W+1]}}};
            end
        end
    end

    // ---------------- output register and skid ----------------
    t_result r_out;
    t_result r_skid;
    logic    r_out_vld;
    logic    r_skid_vld;

    assign en = !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_ready) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (last_vld) begin
            if (!r_out_vld || i_ready) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_ready) begin
                r_out <= r_skid;
            end
        end else if (last_vld) begin
            if (!r_out_vld || i_ready) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_ready         = en;
    assign o_valid         = r_out_vld;
    assign o_overlap       = r_out.ovl;
    assign o_merge_case    = r_out.mcase;
    assign o_merged_x      = r_out.ctr[0];
    assign o_merged_y      = r_out.ctr[1];
    assign o_merged_z      = r_out.ctr[2];
    assign o_merged_radius = r_out.rad;
    assign o_growth        = r_out.growth;

    // ---------------- checks ----------------
    `BSM_ASSERT(a_skid_behind_out, !r_skid_vld || r_out_vld, "skid full, output empty")
    `BSM_ASSERT(a_keep_a_no_growth, !(r_out_vld && (r_out.mcase == CASE_KEEP_A)) || (r_out.growth == '0), "kept A grows")
    `BSM_ASSERT_NEXT(a_stall_fills_skid, r_out_vld && !i_ready && last_vld && !r_skid_vld, r_skid_vld, "stall lost")
    `BSM_ASSERT(a_sq_lanes_agree, m1_vld == {3{m1_vld[0]}}, "square lanes out of step")
    `BSM_ASSERT(a_off_lanes_agree, m2_vld == {3{m2_vld[0]}}, "offset lanes out of step")
    `BSM_ASSERT(a_div_lanes_agree, dv_vld == {3{dv_vld[0]}}, "divider lanes out of step")

endmodule

// ----- src/bsm_mul.sv -----
// Two-stage unsigned multiplier built from four half-width partial products.
`timescale 1ns / 1ps

module bsm_mul #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int TW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bsm_pkg::t_pipe_ctl   i_ctl,
    input  logic [AW-1:0]        i_a,
    input  logic [BW-1:0]        i_b,
    input  logic [TW-1:0]        i_tag,
    output logic                 o_valid,
    output logic [AW+BW-1:0]     o_prod,
    output logic [TW-1:0]        o_tag
);
    import bsm_pkg::*;

    localparam int AL = (AW + 1) / 2;
    localparam int AH = AW - AL;
    localparam int BL = (BW + 1) / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AL+BL-1:0] r_ll;
    logic [AL+BH-1:0] r_lh;
    logic [AH+BL-1:0] r_hl;
    logic [AH+BH-1:0] r_hh;
    logic [TW-1:0]    r_tag1;
    logic [TW-1:0]    r_tag2;
    logic [PW-1:0]    r_prod;
    logic [PW-1:0]    n_prod;
    logic             r_vld1;
    logic             r_vld2;

    // advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_ctl.adv) begin
            r_vld1 <= i_ctl.valid;
            r_vld2 <= r_vld1;
        end
    end

    // combine the partial products
    always_comb begin
        n_prod = (PW'(r_hh) << (AL + BL)) + (PW'(r_lh) << BL) + (PW'(r_hl) << AL)
               + PW'(r_ll);
    end

    // partial products, then the sum
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_ll   <= i_a[AL-1:0] * i_b[BL-1:0];
            r_lh   <= i_a[AL-1:0] * i_b[BW-1:BL];
            r_hl   <= i_a[AW-1:AL] * i_b[BL-1:0];
            r_hh   <= i_a[AW-1:AL] * i_b[BW-1:BL];
            r_tag1 <= i_tag;
            r_prod <= n_prod;
            r_tag2 <= r_tag1;
        end
    end

    assign o_valid = r_vld2;
    assign o_prod  = r_prod;
    assign o_tag   = r_tag2;

endmodule

// ----- src/bsm_isqrt.sv -----
// Pipelined integer square root, one root bit per stage, truncated.
`timescale 1ns / 1ps

module bsm_isqrt #(
    parameter int RB = 33,
    parameter int TW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bsm_pkg::t_pipe_ctl   i_ctl,
    input  logic [2*RB-1:0]      i_rad,
    input  logic [TW-1:0]        i_tag,
    output logic                 o_valid,
    output logic [RB-1:0]        o_root,
    output logic [TW-1:0]        o_tag
);
    import bsm_pkg::*;

    logic [RB+1:0]   r_rem  [RB];
    logic [RB-1:0]   r_root [RB];
    logic [2*RB-1:0] r_rad  [RB];
    logic [TW-1:0]   r_tag  [RB];
    logic [RB-1:0]   r_vld;

    // advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.adv) begin
            r_vld <= {r_vld[RB-2:0], i_ctl.valid};
        end
    end

    for (genvar k = 0; k < RB; k++) begin : g_stage
        logic [RB+1:0]   p_rem;
        logic [RB-1:0]   p_root;
        logic [2*RB-1:0] p_rad;
        logic [TW-1:0]   p_tag;
        logic [RB+1:0]   sh;
        logic [RB+1:0]   trial;
        logic [RB+1:0]   n_rem;
        logic [RB-1:0]   n_root;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_tag  = i_tag;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_tag  = r_tag[k-1];
        end

        // bring down two radicand bits and try the next root bit
        always_comb begin
            sh    = {p_rem[RB-1:0], p_rad[2*(RB-1-k)+1 -: 2]};
            trial = {p_root, 2'b01};
            if (sh >= trial) begin
                n_rem  = sh - trial;
                n_root = {p_root[RB-2:0], 1'b1};
            end else begin
                n_rem  = sh;
                n_root = {p_root[RB-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.adv) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_rad[k]  <= p_rad;
                r_tag[k]  <= p_tag;
            end
        end
    end

    assign o_valid = r_vld[RB-1];
    assign o_root  = r_root[RB-1];
    assign o_tag   = r_tag[RB-1];

endmodule

// ----- src/bsm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, truncated.
`timescale 1ns / 1ps

module bsm_div #(
    parameter int QB = 32,
    parameter int DW = 33,
    parameter int TW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bsm_pkg::t_pipe_ctl   i_ctl,
    input  logic [QB+DW-1:0]     i_num,
    input  logic [DW-1:0]        i_den,
    input  logic [TW-1:0]        i_tag,
    output logic                 o_valid,
    output logic [QB-1:0]        o_quo,
    output logic [TW-1:0]        o_tag
);
    import bsm_pkg::*;

    logic [DW-1:0] r_rem [QB];
    logic [QB-1:0] r_quo [QB];
    logic [QB-1:0] r_low [QB];
    logic [DW-1:0] r_den [QB];
    logic [TW-1:0] r_tag [QB];
    logic [QB-1:0] r_vld;

    // advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.adv) begin
            r_vld <= {r_vld[QB-2:0], i_ctl.valid};
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [DW-1:0] p_rem;
        logic [QB-1:0] p_quo;
        logic [QB-1:0] p_low;
        logic [DW-1:0] p_den;
        logic [TW-1:0] p_tag;
        logic [DW:0]   sh;
        logic [DW:0]   diff;
        logic [DW-1:0] n_rem;
        logic [QB-1:0] n_quo;

        // caller keeps the top part of the dividend below the divisor
        if (k == 0) begin : g_first
            assign p_rem = i_num[QB+DW-1:QB];
            assign p_quo = '0;
            assign p_low = i_num[QB-1:0];
            assign p_den = i_den;
            assign p_tag = i_tag;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_quo = r_quo[k-1];
            assign p_low = r_low[k-1];
            assign p_den = r_den[k-1];
            assign p_tag = r_tag[k-1];
        end

        // shift in one dividend bit and subtract where it fits
        always_comb begin
            sh   = {p_rem, p_low[QB-1-k]};
            diff = sh - {1'b0, p_den};
            if (sh >= {1'b0, p_den}) begin
                n_rem = diff[DW-1:0];
                n_quo = {p_quo[QB-2:0], 1'b1};
            end else begin
                n_rem = sh[DW-1:0];
                n_quo = {p_quo[QB-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.adv) begin
                r_rem[k] <= n_rem;
                r_quo[k] <= n_quo;
                r_low[k] <= p_low;
                r_den[k] <= p_den;
                r_tag[k] <= p_tag;
            end
        end
    end

    assign o_valid = r_vld[QB-1];
    assign o_quo   = r_quo[QB-1];
    assign o_tag   = r_tag[QB-1];

endmodule
